// File: rtl/watc_pkg.sv
// shared types, constants and helpers of the weekly alarm table comparator
`default_nettype none

package watc_pkg;

    localparam int ALARM_COUNT = 8;

    // field widths
    localparam int INDEX_W   = 3;
    localparam int WDAYS_W   = 7;
    localparam int TOD_W     = 17;
    localparam int SOUND_W   = 8;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int SEC_W     = 6;
    localparam int WDAY_W    = 3;
    localparam int USEC_W    = 20;
    localparam int WINDOW_W  = 17;
    localparam int DELAY_W   = 37;

    // internal arithmetic widths
    localparam int NOW_W  = 17;
    localparam int DIFF_W = NOW_W + 1;
    localparam int US_W   = 39;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 56;

    // input tdata layout
    localparam int IN_IDX_LO    = 0;
    localparam int IN_EN_LO     = IN_IDX_LO + INDEX_W;
    localparam int IN_WDAYS_LO  = IN_EN_LO + 1;
    localparam int IN_TOD_LO    = IN_WDAYS_LO + WDAYS_W;
    localparam int IN_SOUND_LO  = IN_TOD_LO + TOD_W;
    localparam int IN_HOUR_LO   = IN_SOUND_LO + SOUND_W;
    localparam int IN_MIN_LO    = IN_HOUR_LO + HOUR_W;
    localparam int IN_SEC_LO    = IN_MIN_LO + MIN_W;
    localparam int IN_WDAY_LO   = IN_SEC_LO + SEC_W;
    localparam int IN_USEC_LO   = IN_WDAY_LO + WDAY_W;
    localparam int IN_WINDOW_LO = IN_USEC_LO + USEC_W;
    localparam int IN_USED_W    = IN_WINDOW_LO + WINDOW_W;

    // output tdata layout
    localparam int OUT_WVALID_LO = 0;
    localparam int OUT_DELAY_LO  = OUT_WVALID_LO + 1;
    localparam int OUT_FOUND_LO  = OUT_DELAY_LO + DELAY_W;
    localparam int OUT_CIDX_LO   = OUT_FOUND_LO + 1;
    localparam int OUT_CSND_LO   = OUT_CIDX_LO + INDEX_W;
    localparam int OUT_USED_W    = OUT_CSND_LO + SOUND_W;

    localparam logic [WDAYS_W-1:0] ALL_DAYS = 7'h7f;

    localparam logic [NOW_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [NOW_W-1:0] SEC_PER_MIN  = 17'd60;

    localparam logic signed [US_W-1:0] US_PER_SEC = 39'sd1000000;
    localparam logic signed [US_W-1:0] US_PER_DAY = 39'sd86400000000;

    // the walk counter covers the candidate pipeline after the query time, then the walk
    localparam int WALK_LEN = ALARM_COUNT + 3;
    localparam int CNT_W    = $clog2(WALK_LEN + 1);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NOW,
        S_WALK
    } t_state;

    typedef struct packed {
        logic               enabled;
        logic [WDAYS_W-1:0] weekdays;
        logic [TOD_W-1:0]   time_of_day;
        logic [SOUND_W-1:0] sound;
    } t_slot;

    typedef struct packed {
        logic [NOW_W-1:0]    now_s;
        logic [USEC_W-1:0]   usec;
        logic [WDAY_W-1:0]   wday;
        logic [WINDOW_W-1:0] window;
    } t_query;

    typedef struct packed {
        logic               wake_valid;
        logic [DELAY_W-1:0] wake_us;
        logic               cur_found;
        logic [INDEX_W-1:0] cur_idx;
        logic [SOUND_W-1:0] cur_sound;
    } t_acc;

    // weekday seven rolls over to Monday like the others
    function automatic logic [WDAY_W-1:0] next_day(input logic [WDAY_W-1:0] d);
        logic [WDAY_W-1:0] r;
        case (d)
            3'd6:    r = 3'd0;
            3'd7:    r = 3'd1;
            default: r = d + 3'd1;
        endcase
        return r;
    endfunction

    // weekday seven lands on the padding bit and never matches
    function automatic logic day_match(input logic [WDAYS_W-1:0] mask,
                                       input logic [WDAY_W-1:0] d);
        logic [7:0] m8;
        m8 = {1'b0, mask};
        return m8[d];
    endfunction

endpackage

`default_nettype wire

// File: rtl/watc_cell.sv
// one alarm slot: stored entry, candidate pipeline and accumulator stage
`default_nettype none

module watc_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire watc_pkg::t_slot              i_wr_slot,
    input  wire watc_pkg::t_query             i_query,
    input  wire logic [watc_pkg::INDEX_W-1:0] i_slot_id,
    input  wire watc_pkg::t_acc               i_acc,
    output watc_pkg::t_acc                    o_acc
);
    import watc_pkg::*;

    t_slot r_slot;

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W-1:0] r_diff_b;
    logic signed [US_W-1:0]   r_us;
    logic                     r_cand_wake;
    logic                     r_cand_cur;
    logic [DELAY_W-1:0]       r_cand_us;
    t_acc                     r_acc;
    t_acc                     n_acc;

    logic signed [US_W-1:0]   diff_ext;
    logic signed [US_W-1:0]   us_wrap;
    logic signed [US_W-1:0]   us_fin;
    logic [WDAY_W-1:0]        day;
    logic signed [DIFF_W:0]   win_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.enabled     <= 1'b0;
            r_slot.weekdays    <= ALL_DAYS;
            r_slot.time_of_day <= '0;
            r_slot.sound       <= '0;
        end else if (i_wr_en) begin
            r_slot <= i_wr_slot;
        end
    end

    assign diff_ext = {{(US_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
    assign us_wrap  = r_us + US_PER_DAY;
    assign day      = r_us[US_W-1] ? next_day(i_query.wday) : i_query.wday;
    assign win_sum  = {r_diff_b[DIFF_W-1], r_diff_b}
                    + $signed({2'b00, i_query.window});

    always_comb begin
        if (!r_us[US_W-1]) begin
            us_fin = r_us;
        end else if (us_wrap[US_W-1]) begin
            us_fin = '0;
        end else begin
            us_fin = us_wrap;
        end
    end

    // candidate pipeline: difference, microseconds, day wrap
    always_ff @(posedge i_clk) begin
        r_diff      <= $signed({1'b0, r_slot.time_of_day}) - $signed({1'b0, i_query.now_s});
        r_diff_b    <= r_diff;
        r_us        <= diff_ext * US_PER_SEC - $signed({{(US_W-USEC_W){1'b0}}, i_query.usec});
        r_cand_us   <= us_fin[DELAY_W-1:0];
        r_cand_wake <= r_slot.enabled && day_match(r_slot.weekdays, day);
        r_cand_cur  <= r_slot.enabled && day_match(r_slot.weekdays, i_query.wday)
                       && (r_diff_b <= 0) && !win_sum[DIFF_W];
    end

    // merge own candidate into the value coming from the lower slot
    always_comb begin
        n_acc = i_acc;
        if (r_cand_wake && (!i_acc.wake_valid || r_cand_us < i_acc.wake_us)) begin
            n_acc.wake_valid = 1'b1;
            n_acc.wake_us    = r_cand_us;
        end
        if (!i_acc.cur_found && r_cand_cur) begin
            n_acc.cur_found = 1'b1;
            n_acc.cur_idx   = i_slot_id;
            n_acc.cur_sound = r_slot.sound;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// File: rtl/weekly_alarm_table_comparator_core.sv
// top level of the weekly alarm table comparator: control, slot chain, result register
//
// usage: one input stream carries write and query items, tuser selects the kind
// (0 writes one slot, 1 queries the table). a write item updates its slot at the
// transfer and the block is ready again in the next cycle; writes give no result.
// a query item gives one result on the output stream: the smallest wake delay in
// microseconds over enabled, weekday-matching slots and the first slot currently
// inside its match window, with sound id.
// a query passes from its transfer through the time of day register, the candidate
// pipeline in each slot cell, the running best as it walks down the chain of cell
// accumulators, and the output register before its result is valid.
// one query is in flight at a time; the next query transfer can come once the
// finished result has been loaded into the output register.
// the result sits in an output register; the next item is taken while it waits.
// if the receiver stalls, a finished query holds at the end of the chain until
// the output register is free, and input ready stays low meanwhile.
// reset: all slots disabled, weekday masks all ones, times and sounds zero,
// no result pending.
`default_nettype none

module weekly_alarm_table_comparator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // entry_index, entry_enabled, entry_weekdays, entry_time_of_day, entry_sound,
    // now_hour, now_minute, now_second, now_weekday, now_microsecond, match_window
    input  wire logic [watc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // cmd
    input  wire logic                            i_s_axis_tuser,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // wake_valid, wake_delay_us, current_found, current_index, current_sound
    output logic [watc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready
);
    import watc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic [CNT_W-1:0] r_cnt;

    logic [HOUR_W-1:0] r_hour;
    logic [MIN_W-1:0]  r_min;
    logic [SEC_W-1:0]  r_sec;
    t_query            r_query;

    logic [OUT_TDATA_W-1:0] r_out;
    logic                   r_out_valid;

    logic   s_accept;
    logic   wr_en;
    logic   q_start;
    logic   out_load;
    logic   walk_done;
    t_slot  wr_slot;
    t_acc   chain [ALARM_COUNT+1];
    t_acc   res;
    logic [IN_TDATA_W-IN_USED_W-1:0] unused_pad;

    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign wr_en      = s_accept && (i_s_axis_tuser == CMD_WRITE);
    assign q_start    = s_accept && (i_s_axis_tuser == CMD_QUERY);
    assign walk_done  = (r_cnt == CNT_W'(WALK_LEN));
    assign unused_pad = i_s_axis_tdata[IN_TDATA_W-1:IN_USED_W];

    assign wr_slot.enabled     = i_s_axis_tdata[IN_EN_LO];
    assign wr_slot.weekdays    = i_s_axis_tdata[IN_WDAYS_LO +: WDAYS_W];
    assign wr_slot.time_of_day = i_s_axis_tdata[IN_TOD_LO +: TOD_W];
    assign wr_slot.sound       = i_s_axis_tdata[IN_SOUND_LO +: SOUND_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (q_start) n_state = S_NOW;
            S_NOW:   n_state = S_WALK;
            S_WALK:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_NOW:   ;
            S_WALK:  out_load = walk_done && (!r_out_valid || i_m_axis_tready);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_NOW) begin
            r_cnt <= '0;
        end else if (!walk_done) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // query time capture, time of day in the following cycle
    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_hour         <= i_s_axis_tdata[IN_HOUR_LO +: HOUR_W];
            r_min          <= i_s_axis_tdata[IN_MIN_LO +: MIN_W];
            r_sec          <= i_s_axis_tdata[IN_SEC_LO +: SEC_W];
            r_query.wday   <= i_s_axis_tdata[IN_WDAY_LO +: WDAY_W];
            r_query.usec   <= i_s_axis_tdata[IN_USEC_LO +: USEC_W];
            r_query.window <= i_s_axis_tdata[IN_WINDOW_LO +: WINDOW_W];
        end
        if (r_state == S_NOW) begin
            r_query.now_s <= NOW_W'(r_hour) * SEC_PER_HOUR + NOW_W'(r_min) * SEC_PER_MIN
                           + NOW_W'(r_sec);
        end
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < ALARM_COUNT; g++) begin : g_cell
        logic sel;
        assign sel = wr_en && ({29'd0, i_s_axis_tdata[IN_IDX_LO +: INDEX_W]} == 32'(g));
        watc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (sel),
            .i_wr_slot (wr_slot),
            .i_query   (r_query),
            .i_slot_id (INDEX_W'(g)),
            .i_acc     (chain[g]),
            .o_acc     (chain[g+1])
        );
    end

    assign res = chain[ALARM_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, res.cur_sound, res.cur_idx,
                      res.cur_found, res.wake_us, res.wake_valid};
        end
    end

    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/watc_checker.sv
// port-level assertions for the weekly alarm table comparator and their bind
`default_nettype none

module watc_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic [watc_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input wire logic                            i_s_axis_tuser,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [watc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready
);
    import watc_pkg::*;

    logic q_xfer;
    logic w_xfer;
    logic [IN_TDATA_W-1:0] unused_in;

    assign q_xfer    = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_QUERY);
    assign w_xfer    = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_WRITE);
    assign unused_in = i_s_axis_tdata;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_no_wake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[OUT_WVALID_LO]
            |-> o_m_axis_tdata[OUT_DELAY_LO +: DELAY_W] == '0)
        else $error("wake delay nonzero without wake valid");

    a_no_cur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[OUT_FOUND_LO]
            |-> o_m_axis_tdata[OUT_CIDX_LO +: INDEX_W + SOUND_W] == '0)
        else $error("current slot fields nonzero without a match");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_xfer |=> !o_s_axis_tready)
        else $error("input ready right after a query transfer");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer |=> o_s_axis_tready)
        else $error("write transfer left the input blocked");

endmodule

bind weekly_alarm_table_comparator_core watc_checker u_watc_checker (.*);

`default_nettype wire

// File: bench/weekly_alarm_table_comparator_core_tb.sv
// testbench for the weekly alarm table comparator: directed and random traffic against a predictor
`timescale 1ns / 100ps

module weekly_alarm_table_comparator_core_tb;
    import watc_pkg::*;

    localparam int    WATCHDOG_LIMIT = 1000;
    localparam int    DRAIN_CYCLES   = 3 * (ALARM_COUNT + 5);
    localparam int    RANDOM_ITEMS   = 800;
    localparam int    MAX_REPORTS    = 10;
    localparam longint USEC_PER_SEC  = 64'd1000000;
    localparam longint USEC_PER_DAY  = 64'd86400000000;
    localparam longint SECS_PER_HOUR = 64'd3600;
    localparam longint SECS_PER_MIN  = 64'd60;
    localparam int    DAYS_IN_WEEK   = 7;
    localparam logic [WDAYS_W-1:0] MONDAY_ONLY = 7'h02;

    // input item as it sits in tdata, first field in the lowest bits
    typedef struct packed {
        logic [IN_TDATA_W-IN_USED_W-1:0] pad;
        logic [WINDOW_W-1:0]             window;
        logic [USEC_W-1:0]               usec;
        logic [WDAY_W-1:0]               wday;
        logic [SEC_W-1:0]                sec;
        logic [MIN_W-1:0]                minute;
        logic [HOUR_W-1:0]               hour;
        logic [SOUND_W-1:0]              sound;
        logic [TOD_W-1:0]                tod;
        logic [WDAYS_W-1:0]              wdays;
        logic                            en;
        logic [INDEX_W-1:0]              idx;
    } t_alarm_item;

    typedef struct packed {
        logic [OUT_TDATA_W-OUT_USED_W-1:0] pad;
        logic [SOUND_W-1:0]                cur_sound;
        logic [INDEX_W-1:0]                cur_idx;
        logic                              cur_found;
        logic [DELAY_W-1:0]                wake_us;
        logic                              wake_valid;
    } t_alarm_report;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   s_user = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_valid;
    logic                   m_ready = 1'b0;

    // slot table as the block should hold it
    logic               slot_en    [ALARM_COUNT];
    logic [WDAYS_W-1:0] slot_wdays [ALARM_COUNT];
    logic [TOD_W-1:0]   slot_tod   [ALARM_COUNT];
    logic [SOUND_W-1:0] slot_sound [ALARM_COUNT];

    t_alarm_report expected_reports[$];
    t_alarm_report got_report;
    t_alarm_report want_report;
    int            fail_count = 0;
    int            idle_cycles = 0;
    bit            quiet = 1'b0;

    weekly_alarm_table_comparator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit weekday_hit(logic [WDAYS_W-1:0] mask, int day);
        if (day >= DAYS_IN_WEEK) begin
            return 1'b0;
        end
        return mask[day];
    endfunction

    function automatic t_alarm_report evaluate_table(t_alarm_item q);
        t_alarm_report r;
        longint        now_s;
        longint        usec;
        longint        win;
        longint        diff;
        longint        us;
        longint        best;
        int            day;
        bit            have_wake;
        bit            have_cur;
        r         = '0;
        best      = 0;
        have_wake = 1'b0;
        have_cur  = 1'b0;
        now_s = longint'(q.hour) * SECS_PER_HOUR + longint'(q.minute) * SECS_PER_MIN
              + longint'(q.sec);
        usec  = longint'(q.usec);
        win   = longint'(q.window);
        for (int i = 0; i < ALARM_COUNT; i++) begin
            if (slot_en[i]) begin
                day  = int'(q.wday);
                diff = longint'(slot_tod[i]) - now_s;
                us   = diff * USEC_PER_SEC - usec;
                // already passed today: same time on the following day
                if (us < 0) begin
                    day = (int'(q.wday) + 1) % DAYS_IN_WEEK;
                    us  = us + USEC_PER_DAY;
                    if (us < 0) begin
                        us = 0;
                    end
                end
                if (weekday_hit(slot_wdays[i], day) && (!have_wake || us < best)) begin
                    best      = us;
                    have_wake = 1'b1;
                end
                if (!have_cur && weekday_hit(slot_wdays[i], int'(q.wday))
                        && diff <= 0 && diff >= -win) begin
                    have_cur    = 1'b1;
                    r.cur_found = 1'b1;
                    r.cur_idx   = i[INDEX_W-1:0];
                    r.cur_sound = slot_sound[i];
                end
            end
        end
        r.wake_valid = have_wake;
        r.wake_us    = have_wake ? best[DELAY_W-1:0] : '0;
        return r;
    endfunction

    function automatic t_alarm_item write_item(int idx, bit en, logic [WDAYS_W-1:0] wdays,
                                               int tod, int snd);
        t_alarm_item it;
        it       = '0;
        it.idx   = idx[INDEX_W-1:0];
        it.en    = en;
        it.wdays = wdays;
        it.tod   = tod[TOD_W-1:0];
        it.sound = snd[SOUND_W-1:0];
        return it;
    endfunction

    function automatic t_alarm_item query_item(int h, int m, int s, int wd, int us, int win);
        t_alarm_item it;
        it        = '0;
        it.hour   = h[HOUR_W-1:0];
        it.minute = m[MIN_W-1:0];
        it.sec    = s[SEC_W-1:0];
        it.wday   = wd[WDAY_W-1:0];
        it.usec   = us[USEC_W-1:0];
        it.window = win[WINDOW_W-1:0];
        return it;
    endfunction

    // drive one item from a falling edge, return at the falling edge after its transfer
    task automatic send_item(t_cmd cmd, t_alarm_item it);
        while (!quiet && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= it;
        @(posedge i_clk);
        while (!s_ready) begin
            @(posedge i_clk);
        end
        if (cmd == CMD_WRITE) begin
            slot_en[it.idx]    = it.en;
            slot_wdays[it.idx] = it.wdays;
            slot_tod[it.idx]   = it.tod;
            slot_sound[it.idx] = it.sound;
        end else begin
            expected_reports.push_back(evaluate_table(it));
        end
        @(negedge i_clk);
    endtask

    task automatic note_failure(string what, t_alarm_report want, t_alarm_report got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected wake %0b/%0d cur %0b/%0d/%0d, got wake %0b/%0d cur %0b/%0d/%0d",
                     $realtime, what, want.wake_valid, want.wake_us, want.cur_found,
                     want.cur_idx, want.cur_sound, got.wake_valid, got.wake_us,
                     got.cur_found, got.cur_idx, got.cur_sound);
        end
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        m_ready <= quiet || ($urandom_range(99) >= 24);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            got_report = t_alarm_report'(m_data);
            if (expected_reports.size() == 0) begin
                note_failure("unexpected result", '0, got_report);
            end else begin
                want_report = expected_reports.pop_front();
                if (got_report.wake_valid !== want_report.wake_valid
                        || got_report.wake_us !== want_report.wake_us
                        || got_report.cur_found !== want_report.cur_found
                        || got_report.cur_idx !== want_report.cur_idx
                        || got_report.cur_sound !== want_report.cur_sound) begin
                    note_failure("result mismatch", want_report, got_report);
                end
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_empty_table();
        // every slot disabled after reset
        send_item(CMD_QUERY, query_item(12, 0, 0, 3, 0, 86400));
    endtask

    task automatic test_wake_delay_wrap();
        send_item(CMD_WRITE, write_item(0, 1'b1, ALL_DAYS, 86399, 255));
        send_item(CMD_WRITE, write_item(1, 1'b1, MONDAY_ONLY, 0, 1));
        send_item(CMD_QUERY, query_item(0, 0, 0, 0, 0, 0));
        // just past the latest alarm of the day, rolls to monday
        send_item(CMD_QUERY, query_item(23, 59, 59, 0, 999999, 0));
        // saturday wraps to sunday
        send_item(CMD_QUERY, query_item(23, 59, 60, 6, 999999, 0));
        send_item(CMD_QUERY, query_item(0, 0, 0, 1, 0, 0));
    endtask

    task automatic test_current_window();
        send_item(CMD_WRITE, write_item(2, 1'b0, ALL_DAYS, 3600, 7));
        send_item(CMD_WRITE, write_item(3, 1'b1, ALL_DAYS, 3600, 8));
        send_item(CMD_WRITE, write_item(4, 1'b1, ALL_DAYS, 3000, 9));
        send_item(CMD_WRITE, write_item(7, 1'b1, 7'h00, 3600, 10));
        // exact hit with a zero window, first enabled slot in index order wins
        send_item(CMD_QUERY, query_item(1, 0, 0, 2, 0, 0));
        send_item(CMD_QUERY, query_item(1, 10, 0, 2, 500000, 600));
        send_item(CMD_QUERY, query_item(1, 10, 1, 2, 0, 599));
    endtask

    task automatic test_out_of_range_time();
        send_item(CMD_WRITE, write_item(5, 1'b1, ALL_DAYS, 0, 128));
        send_item(CMD_WRITE, write_item(6, 1'b1, ALL_DAYS, 131071, 64));
        // weekday seven matches nothing today, tomorrow is monday
        send_item(CMD_QUERY, query_item(31, 63, 63, 7, 1048575, 131071));
        send_item(CMD_QUERY, query_item(0, 0, 0, 7, 0, 131071));
        send_item(CMD_QUERY, query_item(31, 63, 63, 5, 1048575, 131071));
        send_item(CMD_QUERY, query_item(0, 0, 0, 4, 0, 86400));
    endtask

    task automatic test_random_traffic(int n);
        t_alarm_item it;
        t_cmd        cmd;
        int          j;
        int          t;
        for (int k = 0; k < n; k++) begin
            quiet = (k >= n * 3 / 8) && (k < n * 5 / 8);
            it = t_alarm_item'({$urandom, $urandom, $urandom});
            it.pad = '0;
            it.en = ($urandom_range(99) < 75);
            if ($urandom_range(3) == 0) begin
                it.wdays = ALL_DAYS;
            end
            it.tod    = TOD_W'(($urandom_range(15) == 0) ? $urandom_range(86400, 131071)
                                                          : $urandom_range(0, 86399));
            it.hour   = HOUR_W'(($urandom_range(15) == 0) ? $urandom_range(24, 31)
                                                           : $urandom_range(0, 23));
            it.minute = MIN_W'(($urandom_range(15) == 0) ? $urandom_range(60, 63)
                                                          : $urandom_range(0, 59));
            it.sec    = SEC_W'(($urandom_range(15) == 0) ? $urandom_range(61, 63)
                                                          : $urandom_range(0, 60));
            it.wday   = WDAY_W'(($urandom_range(15) == 0) ? 32'd7 : $urandom_range(0, 6));
            it.usec   = USEC_W'(($urandom_range(15) == 0) ? $urandom_range(1000000, 1048575)
                                                           : $urandom_range(0, 999999));
            case ($urandom_range(15))
                0:       it.window = WINDOW_W'($urandom_range(86401, 131071));
                1, 2:    it.window = WINDOW_W'($urandom_range(0, 86400));
                default: it.window = WINDOW_W'($urandom_range(0, 600));
            endcase
            cmd = ($urandom_range(99) < 30) ? CMD_WRITE : CMD_QUERY;
            // half of the queries land just around a stored alarm time
            if (cmd == CMD_QUERY && $urandom_range(1) == 1) begin
                j = $urandom_range(0, ALARM_COUNT - 1);
                t = int'(slot_tod[j]) + int'($urandom_range(0, 150)) - 30;
                if (t < 0) begin
                    t = 0;
                end
                if (t > 86399) begin
                    t = 86399;
                end
                it.hour   = HOUR_W'(t / 3600);
                it.minute = MIN_W'((t / 60) % 60);
                it.sec    = SEC_W'(t % 60);
                it.window = WINDOW_W'($urandom_range(0, 180));
                if ($urandom_range(3) == 0) begin
                    it.usec = '0;
                end
            end
            send_item(cmd, it);
        end
        quiet = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < ALARM_COUNT; i++) begin
            slot_en[i]    = 1'b0;
            slot_wdays[i] = ALL_DAYS;
            slot_tod[i]   = '0;
            slot_sound[i] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_table();
        test_wake_delay_wrap();
        test_current_window();
        test_out_of_range_time();
        test_random_traffic(RANDOM_ITEMS);

        s_valid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/watc_pkg.sv
rtl/watc_cell.sv
rtl/weekly_alarm_table_comparator_core.sv
rtl/watc_checker.sv
bench/weekly_alarm_table_comparator_core_tb.sv
